[rtl/core/svgpr_pkg.sv]
package svgpr_pkg;

   localparam int unsigned ARG_WIDTH = 32;

   localparam logic [3:0] OP_CLOSE        = 4'd0;
   localparam logic [3:0] OP_MOVE         = 4'd1;
   localparam logic [3:0] OP_LINE         = 4'd2;
   localparam logic [3:0] OP_CUBIC        = 4'd3;
   localparam logic [3:0] OP_QUAD         = 4'd4;
   localparam logic [3:0] OP_ARC          = 4'd5;
   localparam logic [3:0] OP_HORIZ        = 4'd6;
   localparam logic [3:0] OP_VERT         = 4'd7;
   localparam logic [3:0] OP_SMOOTH_CUBIC = 4'd8;
   localparam logic [3:0] OP_SMOOTH_QUAD  = 4'd9;

   localparam logic [2:0] SEG_BEGIN  = 3'd0;
   localparam logic [2:0] SEG_CLOSED = 3'd1;
   localparam logic [2:0] SEG_LINE   = 3'd2;
   localparam logic [2:0] SEG_CUBIC  = 3'd3;
   localparam logic [2:0] SEG_QUAD   = 3'd4;
   localparam logic [2:0] SEG_ARC    = 3'd5;

   typedef struct packed {
      logic [3:0]                    op;
      logic                          relative;
      logic signed [ARG_WIDTH-1:0]   arg0;
      logic signed [ARG_WIDTH-1:0]   arg1;
      logic signed [ARG_WIDTH-1:0]   arg2;
      logic signed [ARG_WIDTH-1:0]   arg3;
      logic signed [ARG_WIDTH-1:0]   arg4;
      logic signed [ARG_WIDTH-1:0]   arg5;
      logic signed [ARG_WIDTH-1:0]   arg6;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]                    seg_kind;
      logic signed [ARG_WIDTH-1:0]   ctrl1_x;
      logic signed [ARG_WIDTH-1:0]   ctrl1_y;
      logic signed [ARG_WIDTH-1:0]   ctrl2_x;
      logic signed [ARG_WIDTH-1:0]   ctrl2_y;
      logic signed [ARG_WIDTH-1:0]   end_x;
      logic signed [ARG_WIDTH-1:0]   end_y;
      logic signed [ARG_WIDTH-1:0]   radius_x;
      logic signed [ARG_WIDTH-1:0]   radius_y;
      logic signed [ARG_WIDTH-1:0]   rotation;
      logic                          sweep_clockwise;
      logic                          large_arc;
   } rsp_payload_type;

endpackage

[rtl/core/svg_path_command_resolver.sv]
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  svgpr_pkg::req_payload_type
// rsp_      out        rsp_valid/rsp_stall  svgpr_pkg::rsp_payload_type
//
// One command per cycle unless rsp_stall holds a result; a command passes the input
// register and then the result register, which drives rsp_valid, around the resolve logic.
// Synchronous reset clears current, start and control points and curve flags.
// A stalled result holds the input register; unknown kinds drain without one.
module svg_path_command_resolver #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  svgpr_pkg::req_payload_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output svgpr_pkg::rsp_payload_type rsp_data
);
   import svgpr_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int EW = ((CW > ARG_WIDTH) ? CW : ARG_WIDTH) + 3;
   localparam logic signed [EW-1:0] CMAX_E = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [EW-1:0] CMIN_E = {{(EW-CW+1){1'b1}}, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] CMAX_C = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN_C = {1'b1, {(CW-1){1'b0}}};

   function automatic logic signed [EW-1:0] arg_ext(input logic signed [ARG_WIDTH-1:0] a);
      return {{(EW-ARG_WIDTH){a[ARG_WIDTH-1]}}, a};
   endfunction

   function automatic logic signed [EW-1:0] crd_ext(input logic signed [CW-1:0] c);
      return {{(EW-CW){c[CW-1]}}, c};
   endfunction

   function automatic logic signed [CW-1:0] sat(input logic signed [EW-1:0] v);
      logic signed [CW-1:0] r;
      if (v > CMAX_E) begin
         r = CMAX_C;
      end else if (v < CMIN_E) begin
         r = CMIN_C;
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [CW-1:0] resolve(input logic rel,
                                                    input logic signed [CW-1:0] cur,
                                                    input logic signed [ARG_WIDTH-1:0] a);
      logic signed [EW-1:0] s;
      s = rel ? (crd_ext(cur) + arg_ext(a)) : arg_ext(a);
      return sat(s);
   endfunction

   function automatic logic signed [CW-1:0] reflect(input logic signed [CW-1:0] cur,
                                                    input logic signed [CW-1:0] ctl);
      return sat(crd_ext(cur) + crd_ext(cur) - crd_ext(ctl));
   endfunction

   function automatic logic signed [ARG_WIDTH-1:0] to_out(input logic signed [CW-1:0] c);
      logic signed [EW-1:0] e;
      e = crd_ext(c);
      return e[ARG_WIDTH-1:0];
   endfunction

   logic                   s1_valid_ff, s1_valid_in;
   req_payload_type        s1_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic signed [CW-1:0]   cur_x_ff, cur_y_ff, start_x_ff, start_y_ff, ctl_x_ff, ctl_y_ff;
   logic signed [CW-1:0]   cur_x_in, cur_y_in, start_x_in, start_y_in, ctl_x_in, ctl_y_in;
   logic                   prev_cubic_ff, prev_quad_ff, prev_cubic_in, prev_quad_in;

   logic                   req_accept, rsp_free, op_known, s1_move;
   logic signed [CW-1:0]   c1x, c1y, c2x, c2y, ex, ey;
   logic signed [CW-1:0]   p01x, p01y, p23x, p23y, p45x, p45y, p56x, p56y, pvy;
   logic signed [CW-1:0]   refl_x, refl_y;

   assign op_known   = s1_data_ff.op inside {[OP_CLOSE:OP_SMOOTH_QUAD]};
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && (!op_known || rsp_free);
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;
   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = (s1_move && op_known) || (rsp_valid_ff && rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      p01x   = resolve(s1_data_ff.relative, cur_x_ff, s1_data_ff.arg0);
      p01y   = resolve(s1_data_ff.relative, cur_y_ff, s1_data_ff.arg1);
      p23x   = resolve(s1_data_ff.relative, cur_x_ff, s1_data_ff.arg2);
      p23y   = resolve(s1_data_ff.relative, cur_y_ff, s1_data_ff.arg3);
      p45x   = resolve(s1_data_ff.relative, cur_x_ff, s1_data_ff.arg4);
      p45y   = resolve(s1_data_ff.relative, cur_y_ff, s1_data_ff.arg5);
      p56x   = resolve(s1_data_ff.relative, cur_x_ff, s1_data_ff.arg5);
      p56y   = resolve(s1_data_ff.relative, cur_y_ff, s1_data_ff.arg6);
      pvy    = resolve(s1_data_ff.relative, cur_y_ff, s1_data_ff.arg0);
      refl_x = reflect(cur_x_ff, ctl_x_ff);
      refl_y = reflect(cur_y_ff, ctl_y_ff);
   end

   always_comb begin
      rsp_data_in   = '0;
      c1x           = '0;
      c1y           = '0;
      c2x           = '0;
      c2y           = '0;
      ex            = cur_x_ff;
      ey            = cur_y_ff;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      ctl_x_in      = ctl_x_ff;
      ctl_y_in      = ctl_y_ff;
      prev_cubic_in = 1'b0;
      prev_quad_in  = 1'b0;
      case (s1_data_ff.op)
         OP_CLOSE: begin
            rsp_data_in.seg_kind = SEG_CLOSED;
            ex = start_x_ff;
            ey = start_y_ff;
         end
         OP_MOVE: begin
            rsp_data_in.seg_kind = SEG_BEGIN;
            ex = p01x;
            ey = p01y;
            start_x_in = p01x;
            start_y_in = p01y;
         end
         OP_LINE: begin
            rsp_data_in.seg_kind = SEG_LINE;
            ex = p01x;
            ey = p01y;
         end
         OP_CUBIC: begin
            rsp_data_in.seg_kind = SEG_CUBIC;
            c1x = p01x;
            c1y = p01y;
            c2x = p23x;
            c2y = p23y;
            ex  = p45x;
            ey  = p45y;
            ctl_x_in = p23x;
            ctl_y_in = p23y;
            prev_cubic_in = 1'b1;
         end
         OP_QUAD: begin
            rsp_data_in.seg_kind = SEG_QUAD;
            c1x = p01x;
            c1y = p01y;
            ex  = p23x;
            ey  = p23y;
            ctl_x_in = p01x;
            ctl_y_in = p01y;
            prev_quad_in = 1'b1;
         end
         OP_ARC: begin
            rsp_data_in.seg_kind        = SEG_ARC;
            rsp_data_in.radius_x        = s1_data_ff.arg0;
            rsp_data_in.radius_y        = s1_data_ff.arg1;
            rsp_data_in.rotation        = s1_data_ff.arg2;
            rsp_data_in.large_arc       = (s1_data_ff.arg3 != '0);
            rsp_data_in.sweep_clockwise = (s1_data_ff.arg4 != '0);
            ex = p56x;
            ey = p56y;
         end
         OP_HORIZ: begin
            rsp_data_in.seg_kind = SEG_LINE;
            ex = p01x;
         end
         OP_VERT: begin
            rsp_data_in.seg_kind = SEG_LINE;
            ey = pvy;
         end
         OP_SMOOTH_CUBIC: begin
            rsp_data_in.seg_kind = SEG_CUBIC;
            c1x = prev_cubic_ff ? refl_x : cur_x_ff;
            c1y = prev_cubic_ff ? refl_y : cur_y_ff;
            c2x = p01x;
            c2y = p01y;
            ex  = p23x;
            ey  = p23y;
            ctl_x_in = p01x;
            ctl_y_in = p01y;
            prev_cubic_in = 1'b1;
         end
         OP_SMOOTH_QUAD: begin
            rsp_data_in.seg_kind = SEG_QUAD;
            c1x = prev_quad_ff ? refl_x : cur_x_ff;
            c1y = prev_quad_ff ? refl_y : cur_y_ff;
            ex  = p01x;
            ey  = p01y;
            ctl_x_in = c1x;
            ctl_y_in = c1y;
            prev_quad_in = 1'b1;
         end
         default: begin
            prev_cubic_in = prev_cubic_ff;
            prev_quad_in  = prev_quad_ff;
         end
      endcase
      cur_x_in = ex;
      cur_y_in = ey;
      rsp_data_in.ctrl1_x = to_out(c1x);
      rsp_data_in.ctrl1_y = to_out(c1y);
      rsp_data_in.ctrl2_x = to_out(c2x);
      rsp_data_in.ctrl2_y = to_out(c2y);
      rsp_data_in.end_x   = to_out(ex);
      rsp_data_in.end_y   = to_out(ey);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         ctl_x_ff      <= '0;
         ctl_y_ff      <= '0;
         prev_cubic_ff <= 1'b0;
         prev_quad_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move && op_known) begin
            cur_x_ff      <= cur_x_in;
            cur_y_ff      <= cur_y_in;
            start_x_ff    <= start_x_in;
            start_y_ff    <= start_y_in;
            ctl_x_ff      <= ctl_x_in;
            ctl_y_ff      <= ctl_y_in;
            prev_cubic_ff <= prev_cubic_in;
            prev_quad_ff  <= prev_quad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
      if (s1_move && op_known) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_unknown_drains: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !op_known) |-> !req_stall)
      else $error("unknown command blocked the input");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && op_known && rsp_valid_ff && rsp_stall)
      |=> (s1_valid_ff && $stable(s1_data_ff) && $stable(cur_x_ff) && $stable(cur_y_ff)))
      else $error("pending command or state changed while result stalled");

   a_close_returns: assert property (@(posedge clock) disable iff (reset)
      (s1_move && s1_data_ff.op == OP_CLOSE)
      |=> (cur_x_ff == start_x_ff && cur_y_ff == start_y_ff
           && !prev_cubic_ff && !prev_quad_ff))
      else $error("close did not return to figure start");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import svgpr_pkg::*;

   localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] COORD_MIN = 32'h8000_0000;
   localparam logic [31:0] ONE       = 32'h0001_0000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   rsp_payload_type expected_segments[$];
   int              mismatch_count = 0;

   bit sender_gaps_on     = 1'b0;
   bit receiver_stalls_on = 1'b0;
   int hold_request       = 0;
   int hold_left          = 0;
   int stall_left         = 0;

   // path state tracked alongside the block
   logic [31:0] cur_x = '0, cur_y = '0;
   logic [31:0] fig_x = '0, fig_y = '0;
   logic [31:0] ctl_x = '0, ctl_y = '0;
   bit          prev_was_cubic = 1'b0;
   bit          prev_was_quad  = 1'b0;

   svg_path_command_resolver u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] saturate(input longint v);
      if (v > 64'sd2147483647) return COORD_MAX;
      if (v < -64'sd2147483648) return COORD_MIN;
      return v[31:0];
   endfunction

   function automatic logic [31:0] locate(input logic rel, input logic [31:0] base,
                                          input logic [31:0] operand);
      if (rel) return saturate(longint'($signed(base)) + longint'($signed(operand)));
      return operand;
   endfunction

   function automatic logic [31:0] mirror(input logic [31:0] pivot, input logic [31:0] ctl);
      return saturate(2 * longint'($signed(pivot)) - longint'($signed(ctl)));
   endfunction

   function automatic bit resolve_command(input req_payload_type cmd,
                                          output rsp_payload_type seg);
      logic [31:0] ex, ey;
      bit          cubic_now, quad_now;
      seg = '0;
      cubic_now = 1'b0;
      quad_now  = 1'b0;
      case (cmd.op)
         OP_CLOSE: begin
            seg.seg_kind = SEG_CLOSED;
            ex = fig_x;
            ey = fig_y;
         end
         OP_MOVE: begin
            seg.seg_kind = SEG_BEGIN;
            ex = locate(cmd.relative, cur_x, cmd.arg0);
            ey = locate(cmd.relative, cur_y, cmd.arg1);
            fig_x = ex;
            fig_y = ey;
         end
         OP_LINE: begin
            seg.seg_kind = SEG_LINE;
            ex = locate(cmd.relative, cur_x, cmd.arg0);
            ey = locate(cmd.relative, cur_y, cmd.arg1);
         end
         OP_CUBIC: begin
            seg.seg_kind = SEG_CUBIC;
            seg.ctrl1_x = locate(cmd.relative, cur_x, cmd.arg0);
            seg.ctrl1_y = locate(cmd.relative, cur_y, cmd.arg1);
            seg.ctrl2_x = locate(cmd.relative, cur_x, cmd.arg2);
            seg.ctrl2_y = locate(cmd.relative, cur_y, cmd.arg3);
            ex = locate(cmd.relative, cur_x, cmd.arg4);
            ey = locate(cmd.relative, cur_y, cmd.arg5);
            ctl_x = seg.ctrl2_x;
            ctl_y = seg.ctrl2_y;
            cubic_now = 1'b1;
         end
         OP_QUAD: begin
            seg.seg_kind = SEG_QUAD;
            seg.ctrl1_x = locate(cmd.relative, cur_x, cmd.arg0);
            seg.ctrl1_y = locate(cmd.relative, cur_y, cmd.arg1);
            ex = locate(cmd.relative, cur_x, cmd.arg2);
            ey = locate(cmd.relative, cur_y, cmd.arg3);
            ctl_x = seg.ctrl1_x;
            ctl_y = seg.ctrl1_y;
            quad_now = 1'b1;
         end
         OP_ARC: begin
            seg.seg_kind = SEG_ARC;
            seg.radius_x = cmd.arg0;
            seg.radius_y = cmd.arg1;
            seg.rotation = cmd.arg2;
            seg.large_arc = |cmd.arg3;
            seg.sweep_clockwise = |cmd.arg4;
            ex = locate(cmd.relative, cur_x, cmd.arg5);
            ey = locate(cmd.relative, cur_y, cmd.arg6);
         end
         OP_HORIZ: begin
            seg.seg_kind = SEG_LINE;
            ex = locate(cmd.relative, cur_x, cmd.arg0);
            ey = cur_y;
         end
         OP_VERT: begin
            seg.seg_kind = SEG_LINE;
            ex = cur_x;
            ey = locate(cmd.relative, cur_y, cmd.arg0);
         end
         OP_SMOOTH_CUBIC: begin
            seg.seg_kind = SEG_CUBIC;
            seg.ctrl1_x = prev_was_cubic ? mirror(cur_x, ctl_x) : cur_x;
            seg.ctrl1_y = prev_was_cubic ? mirror(cur_y, ctl_y) : cur_y;
            seg.ctrl2_x = locate(cmd.relative, cur_x, cmd.arg0);
            seg.ctrl2_y = locate(cmd.relative, cur_y, cmd.arg1);
            ex = locate(cmd.relative, cur_x, cmd.arg2);
            ey = locate(cmd.relative, cur_y, cmd.arg3);
            ctl_x = seg.ctrl2_x;
            ctl_y = seg.ctrl2_y;
            cubic_now = 1'b1;
         end
         OP_SMOOTH_QUAD: begin
            seg.seg_kind = SEG_QUAD;
            seg.ctrl1_x = prev_was_quad ? mirror(cur_x, ctl_x) : cur_x;
            seg.ctrl1_y = prev_was_quad ? mirror(cur_y, ctl_y) : cur_y;
            ex = locate(cmd.relative, cur_x, cmd.arg0);
            ey = locate(cmd.relative, cur_y, cmd.arg1);
            ctl_x = seg.ctrl1_x;
            ctl_y = seg.ctrl1_y;
            quad_now = 1'b1;
         end
         default: return 1'b0;
      endcase
      seg.end_x = ex;
      seg.end_y = ey;
      cur_x = ex;
      cur_y = ey;
      prev_was_cubic = cubic_now;
      prev_was_quad  = quad_now;
      return 1'b1;
   endfunction

   function automatic int pick_idle_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 15))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return '0;
         3, 4:    return $urandom();
         default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      endcase
   endfunction

   function automatic logic [31:0] random_flag();
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return ONE;
         default: return $urandom();
      endcase
   endfunction

   function automatic req_payload_type make_command(
      input logic [3:0] op, input logic rel,
      input logic [31:0] a0, input logic [31:0] a1, input logic [31:0] a2,
      input logic [31:0] a3, input logic [31:0] a4, input logic [31:0] a5,
      input logic [31:0] a6);
      req_payload_type cmd;
      cmd.op = op;
      cmd.relative = rel;
      cmd.arg0 = a0;
      cmd.arg1 = a1;
      cmd.arg2 = a2;
      cmd.arg3 = a3;
      cmd.arg4 = a4;
      cmd.arg5 = a5;
      cmd.arg6 = a6;
      return cmd;
   endfunction

   function automatic req_payload_type random_command(input logic [3:0] op);
      req_payload_type cmd;
      cmd = make_command(op, 1'($urandom_range(0, 1)), random_operand(), random_operand(),
                         random_operand(), random_operand(), random_operand(),
                         random_operand(), random_operand());
      if (op == OP_ARC) begin
         cmd.arg3 = random_flag();
         cmd.arg4 = random_flag();
      end
      return cmd;
   endfunction

   task automatic send_command(input req_payload_type cmd);
      rsp_payload_type seg;
      int              gap;
      gap = 0;
      if (sender_gaps_on && $urandom_range(0, 1)) gap = pick_idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (resolve_command(cmd, seg))
         expected_segments.insert(expected_segments.size(), seg);
   endtask

   task automatic drop_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // receiver: long hold-off on request, else random stalls
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (receiver_stalls_on && $urandom_range(0, 99) < 25) begin
         stall_left = pick_idle_length() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type exp_seg;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_segments.size() == 0) begin
            $error("segment transfer with none outstanding: kind %0d", rsp_data.seg_kind);
            mismatch_count++;
         end else begin
            exp_seg = expected_segments.pop_front();
            check_field("seg_kind", 32'(exp_seg.seg_kind), 32'(rsp_data.seg_kind));
            check_field("ctrl1_x", exp_seg.ctrl1_x, rsp_data.ctrl1_x);
            check_field("ctrl1_y", exp_seg.ctrl1_y, rsp_data.ctrl1_y);
            check_field("ctrl2_x", exp_seg.ctrl2_x, rsp_data.ctrl2_x);
            check_field("ctrl2_y", exp_seg.ctrl2_y, rsp_data.ctrl2_y);
            check_field("end_x", exp_seg.end_x, rsp_data.end_x);
            check_field("end_y", exp_seg.end_y, rsp_data.end_y);
            check_field("radius_x", exp_seg.radius_x, rsp_data.radius_x);
            check_field("radius_y", exp_seg.radius_y, rsp_data.radius_y);
            check_field("rotation", exp_seg.rotation, rsp_data.rotation);
            check_field("sweep_clockwise", 32'(exp_seg.sweep_clockwise),
                        32'(rsp_data.sweep_clockwise));
            check_field("large_arc", 32'(exp_seg.large_arc), 32'(rsp_data.large_arc));
         end
      end
   end

   task automatic test_directed();
      int k;
      sender_gaps_on = 1'b0;
      receiver_stalls_on = 1'b0;
      send_command(make_command(OP_MOVE, 1'b0, COORD_MAX, COORD_MIN, '1, '1, '1, '1, '1));
      // relative offsets past the range edges saturate
      send_command(make_command(OP_LINE, 1'b1, ONE, -ONE, '0, '0, '0, '0, '0));
      send_command(make_command(OP_HORIZ, 1'b0, '0, COORD_MAX, '0, '0, '0, '0, '0));
      send_command(make_command(OP_VERT, 1'b1, COORD_MIN, '0, '0, '0, '0, '0, '0));
      send_command(make_command(OP_CUBIC, 1'b0, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                                COORD_MAX, COORD_MIN, '0));
      // reflection beyond both range edges
      send_command(make_command(OP_SMOOTH_CUBIC, 1'b0, '0, '0, '0, '0, '1, '1, '1));
      send_command(make_command(OP_SMOOTH_CUBIC, 1'b1, 3 * ONE, -ONE, ONE, 2 * ONE,
                                '0, '0, '0));
      send_command(make_command(OP_QUAD, 1'b1, -2 * ONE, 5 * ONE, 7 * ONE, -ONE,
                                '0, '0, '0));
      send_command(make_command(OP_SMOOTH_QUAD, 1'b0, 10 * ONE, 10 * ONE, '0, '0, '0, '0, '0));
      send_command(make_command(OP_SMOOTH_QUAD, 1'b1, COORD_MAX, COORD_MIN, '0, '0, '0, '0,
                                '0));
      // smooth curve after the other curve kind uses the current point
      send_command(make_command(OP_SMOOTH_CUBIC, 1'b0, ONE, ONE, 2 * ONE, 2 * ONE,
                                '0, '0, '0));
      send_command(make_command(OP_SMOOTH_QUAD, 1'b0, 4 * ONE, -4 * ONE, '0, '0, '0, '0, '0));
      send_command(make_command(OP_ARC, 1'b0, COORD_MIN, COORD_MAX, 32'h005A_0000,
                                COORD_MIN, '0, -3 * ONE, 9 * ONE));
      send_command(make_command(OP_ARC, 1'b1, '1, '0, COORD_MAX, '0, 32'h0000_0001,
                                COORD_MAX, COORD_MIN));
      send_command(make_command(OP_SMOOTH_CUBIC, 1'b0, '0, ONE, ONE, '0, '0, '0, '0));
      send_command(make_command(OP_CLOSE, 1'b1, '1, '1, '1, '1, '1, '1, '1));
      for (k = 10; k <= 15; k++)
         send_command(make_command(k[3:0], k[0], '1, '1, '1, '1, '1, '1, '1));
      send_command(make_command(OP_LINE, 1'b1, ONE, ONE, '0, '0, '0, '0, '0));
      send_command(make_command(OP_SMOOTH_QUAD, 1'b0, '0, '0, '0, '0, '0, '0, '0));
      send_command(make_command(OP_MOVE, 1'b1, COORD_MIN, COORD_MAX, '0, '0, '0, '0, '0));
      drop_request();
   endtask

   task automatic send_figure(output int sent);
      logic [3:0] op, last_op;
      int         k, segments;
      sent = 0;
      send_command(random_command(OP_MOVE));
      sent++;
      last_op = OP_MOVE;
      segments = $urandom_range(1, 8);
      for (k = 0; k < segments; k++) begin
         op = 4'($urandom_range(OP_LINE, OP_SMOOTH_QUAD));
         if ((last_op == OP_CUBIC || last_op == OP_SMOOTH_CUBIC) && $urandom_range(0, 1))
            op = OP_SMOOTH_CUBIC;
         else if ((last_op == OP_QUAD || last_op == OP_SMOOTH_QUAD) && $urandom_range(0, 1))
            op = OP_SMOOTH_QUAD;
         if ($urandom_range(0, 19) == 0)
            send_command(random_command(4'($urandom_range(10, 15))));
         send_command(random_command(op));
         sent++;
         last_op = op;
      end
      if ($urandom_range(0, 4) < 3) begin
         send_command(random_command(OP_CLOSE));
         sent++;
      end
   endtask

   task automatic test_streaming();
      int sent, total;
      sender_gaps_on = 1'b0;
      receiver_stalls_on = 1'b0;
      total = 0;
      while (total < 200) begin
         send_figure(sent);
         total += sent;
      end
      drop_request();
   endtask

   task automatic test_random_figures();
      int sent, total;
      total = 0;
      while (total < 1300) begin
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         receiver_stalls_on = ($urandom_range(0, 3) != 0);
         send_figure(sent);
         total += sent;
      end
      drop_request();
   endtask

   task automatic test_backpressure();
      int k;
      sender_gaps_on = 1'b0;
      receiver_stalls_on = 1'b0;
      hold_request = 300;
      for (k = 0; k < 60; k++)
         send_command(random_command(4'($urandom_range(OP_CLOSE, OP_SMOOTH_QUAD))));
      drop_request();
   endtask

   task automatic test_noise();
      int k;
      sender_gaps_on = 1'b1;
      receiver_stalls_on = 1'b1;
      for (k = 0; k < 350; k++)
         send_command(random_command(4'($urandom_range(0, 15))));
      drop_request();
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_streaming();
      test_random_figures();
      test_backpressure();
      test_noise();
      receiver_stalls_on = 1'b0;
      wait (expected_segments.size() == 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_segments.size() == 0)
         $display("[svg_path_command_resolver] OK");
      else
         $display("[svg_path_command_resolver] ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[svg_path_command_resolver] ERROR");
      $finish;
   end

endmodule
